// ===== rtl/ljsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ljsd_pkg
// Shared types and constants for the lossless jpeg scan decoder.
// ----------------------------------------------------------------------------
package ljsd_pkg;

    // input transfer payload
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       frame_start;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [15:0] sample_value;
        logic        component;
        logic [15:0] column;
        logic [15:0] row;
        logic [1:0]  status;
        logic        last_sample;
    } t_out_item;

    // result status codes
    localparam logic [1:0] ST_SAMPLE    = 2'd0;
    localparam logic [1:0] ST_UNUSED    = 2'd1;
    localparam logic [1:0] ST_BAD_MARK  = 2'd2;
    localparam logic [1:0] ST_EARLY_EOI = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_COUNTS0  = 3'd2;
    localparam logic [2:0] CFG_SYMBOLS0 = 3'd3;
    localparam logic [2:0] CFG_COUNTS1  = 3'd4;
    localparam logic [2:0] CFG_SYMBOLS1 = 3'd5;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_EOI    = 8'hD9;
    localparam logic [7:0] STUFF_BYTE    = 8'h00;

    // command classes from the byte classifier
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_DATA,
        CMD_EOI,
        CMD_BAD
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       start;
    } t_cmd;

endpackage

// ===== rtl/ljsd_front.sv =====
// ----------------------------------------------------------------------------
// ljsd_front
// Byte classifier: strips byte stuffing and sorts markers into commands.
// ----------------------------------------------------------------------------
module ljsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ljsd_pkg::t_in_item i_item,
    output logic               o_push,
    output ljsd_pkg::t_cmd     o_cmd
);

    logic r_prefix;
    logic n_prefix;
    logic prefix_eff;

    // classify the byte against the prefix state
    always_comb begin
        prefix_eff   = r_prefix && !i_item.frame_start;
        n_prefix     = 1'b0;
        o_cmd.start  = i_item.frame_start;
        o_cmd.data   = i_item.stream_byte;
        o_cmd.kind   = ljsd_pkg::CMD_DATA;
        if (prefix_eff) begin
            if (i_item.stream_byte == ljsd_pkg::MARKER_EOI) begin
                o_cmd.kind = ljsd_pkg::CMD_EOI;
            end else if (i_item.stream_byte != ljsd_pkg::STUFF_BYTE) begin
                o_cmd.kind = ljsd_pkg::CMD_BAD;
            end else begin
                o_cmd.data = ljsd_pkg::MARKER_PREFIX;
            end
        end else if (i_item.stream_byte == ljsd_pkg::MARKER_PREFIX) begin
            o_cmd.kind = ljsd_pkg::CMD_NONE;
            n_prefix   = 1'b1;
        end
        o_push = i_accept && (o_cmd.kind != ljsd_pkg::CMD_NONE || i_item.frame_start);
    end

    // prefix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
        end else if (i_accept) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== rtl/ljsd_cmdq.sv =====
// ----------------------------------------------------------------------------
// ljsd_cmdq
// Two-entry command queue between the classifier and the decoder.
// ----------------------------------------------------------------------------
module ljsd_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ljsd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ljsd_pkg::t_cmd o_cmd
);

    ljsd_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/ljsd_back.sv =====
// ----------------------------------------------------------------------------
// ljsd_back
// Huffman decode, residual extraction and predictor-1 reconstruction,
// one code length or one sample per cycle while the output is not stalled, with a registered output.
// ----------------------------------------------------------------------------
module ljsd_back #(
    parameter int SAMPLE_BITS   = 16,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_q_valid,
    input  ljsd_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output ljsd_pkg::t_out_item o_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RUN
    } t_state;

    localparam logic [15:0] PRED_INIT = 16'(1) << (SAMPLE_BITS - 1);

    // configuration
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [63:0] r_counts  [2];
    logic [59:0] r_symbols [2];

    // decode state
    t_state              r_state;
    ljsd_pkg::t_cmd      r_cmd;
    logic [31:0]         r_win;
    logic [5:0]          r_held;
    logic [4:0]          r_pend;
    logic [15:0]         r_pred [2];
    logic [15:0]         r_rfs  [2];
    logic [15:0]         r_col;
    logic [15:0]         r_row;
    logic                r_comp;
    logic                r_fin;
    logic [3:0]          r_n;
    logic [4:0]          r_len;
    logic [20:0]         r_code;
    logic [7:0]          r_idx;
    ljsd_pkg::t_out_item r_out;
    logic                r_out_vld;

    logic        slot_free;
    logic [63:0] cur_counts;
    logic [59:0] cur_syms;
    logic [4:0]  maxlen;
    logic [3:0]  cnt;
    logic [3:0]  cat;
    logic [4:0]  nsel;
    logic [5:0]  shamt;
    logic [31:0] tb;
    logic [20:0] v21;
    logic [20:0] diff;
    logic        match;
    logic [8:0]  k;
    logic [3:0]  sym;
    logic [15:0] m;
    logic [15:0] resid;
    logic [15:0] pred;
    logic [15:0] val;
    logic        last;
    logic        row_end;
    logic [6:0]  held_sum;

    assign slot_free = !r_out_vld || !i_stall;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_valid   = r_out_vld;
    assign o_item    = r_out;

    // table lookups, bit extraction and reconstruction
    always_comb begin
        cur_counts = r_counts[r_comp];
        cur_syms   = r_symbols[r_comp];
        maxlen     = 5'd0;
        for (int l = 1; l <= MAX_CODE_BITS; l++) begin
            if (cur_counts[4*(l-1) +: 4] != 4'd0) begin
                maxlen = 5'(l);
            end
        end
        cnt   = 4'(cur_counts >> {4'(r_len - 5'd1), 2'b00});
        cat   = 4'(r_pend - 5'd1);
        nsel  = (r_pend == 5'd0) ? r_len : {1'b0, cat};
        shamt = r_held - {1'b0, nsel};
        tb    = (r_win >> shamt) & ((32'd1 << nsel) - 32'd1);
        v21   = 21'(tb);
        diff  = v21 - r_code;
        match = (v21 >= r_code) && (diff < 21'(cnt));
        k     = {1'b0, r_idx} + 9'(diff[3:0]);
        sym   = 4'(cur_syms >> {k[3:0], 2'b00});
        m     = tb[15:0];
        if (cat == 4'd0) begin
            resid = 16'd0;
        end else if (m[cat - 4'd1]) begin
            resid = m;
        end else begin
            resid = m - ((16'd1 << cat) - 16'd1);
        end
        if (r_col == 16'd0) begin
            pred = (r_row == 16'd0) ? PRED_INIT : r_rfs[r_comp];
        end else begin
            pred = r_pred[r_comp];
        end
        val      = pred + resid;
        row_end  = ({1'b0, r_col} + 17'd1) >= {1'b0, r_width};
        last     = r_comp && row_end && (({1'b0, r_row} + 17'd1) >= {1'b0, r_height});
        held_sum = {1'b0, r_held} + 7'd8;
    end

    // sequencer, decode state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_width      <= 16'd1;
            r_height     <= 16'd1;
            r_counts[0]  <= '0;
            r_counts[1]  <= '0;
            r_symbols[0] <= '0;
            r_symbols[1] <= '0;
            r_win        <= '0;
            r_held       <= '0;
            r_pend       <= '0;
            r_pred[0]    <= '0;
            r_pred[1]    <= '0;
            r_rfs[0]     <= '0;
            r_rfs[1]     <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_comp       <= 1'b0;
            r_fin        <= 1'b0;
            r_n          <= '0;
            r_len        <= 5'd1;
            r_code       <= '0;
            r_idx        <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ljsd_pkg::CFG_WIDTH:    r_width      <= i_cfg_data[15:0];
                    ljsd_pkg::CFG_HEIGHT:   r_height     <= i_cfg_data[15:0];
                    ljsd_pkg::CFG_COUNTS0:  r_counts[0]  <= i_cfg_data;
                    ljsd_pkg::CFG_SYMBOLS0: r_symbols[0] <= i_cfg_data[59:0];
                    ljsd_pkg::CFG_COUNTS1:  r_counts[1]  <= i_cfg_data;
                    ljsd_pkg::CFG_SYMBOLS1: r_symbols[1] <= i_cfg_data[59:0];
                    default: ;
                endcase
            end

            if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= S_EXEC;
                        if (i_q_cmd.start) begin
                            r_win     <= '0;
                            r_held    <= '0;
                            r_pend    <= '0;
                            r_pred[0] <= '0;
                            r_pred[1] <= '0;
                            r_rfs[0]  <= '0;
                            r_rfs[1]  <= '0;
                            r_col     <= '0;
                            r_row     <= '0;
                            r_comp    <= 1'b0;
                            r_fin     <= 1'b0;
                        end
                    end
                end
                S_EXEC: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                        if (!r_fin) begin
                            unique case (r_cmd.kind)
                                ljsd_pkg::CMD_EOI, ljsd_pkg::CMD_BAD: begin
                                    r_out.sample_value <= '0;
                                    r_out.component    <= r_comp;
                                    r_out.column       <= r_col;
                                    r_out.row          <= r_row;
                                    r_out.status       <= (r_cmd.kind == ljsd_pkg::CMD_EOI) ?
                                                          ljsd_pkg::ST_EARLY_EOI :
                                                          ljsd_pkg::ST_BAD_MARK;
                                    r_out.last_sample  <= 1'b0;
                                    r_out_vld          <= 1'b1;
                                    r_fin              <= 1'b1;
                                end
                                ljsd_pkg::CMD_DATA: begin
                                    r_win   <= {r_win[23:0], r_cmd.data};
                                    r_held  <= (held_sum > 7'd32) ? 6'd32 : held_sum[5:0];
                                    r_n     <= '0;
                                    r_len   <= 5'd1;
                                    r_code  <= '0;
                                    r_idx   <= '0;
                                    r_state <= S_RUN;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_RUN: begin
                    if (slot_free) begin
                        r_out.component <= r_comp;
                        r_out.column    <= r_col;
                        r_out.row       <= r_row;
                        if (r_fin || r_n == 4'd8) begin
                            r_state <= S_IDLE;
                        end else if (r_pend == 5'd0) begin
                            // one code length per cycle while the output slot is free
                            r_out.sample_value <= '0;
                            r_out.status       <= ljsd_pkg::ST_UNUSED;
                            r_out.last_sample  <= 1'b0;
                            if (maxlen == 5'd0) begin
                                if (r_held != 6'd0) begin
                                    r_out_vld <= 1'b1;
                                    r_fin     <= 1'b1;
                                end
                                r_state <= S_IDLE;
                            end else if ({1'b0, r_held} < {2'b00, r_len}) begin
                                r_state <= S_IDLE;
                            end else if (match) begin
                                r_len  <= 5'd1;
                                r_code <= '0;
                                r_idx  <= '0;
                                if (k >= 9'd15) begin
                                    r_out_vld <= 1'b1;
                                    r_fin     <= 1'b1;
                                    r_n       <= r_n + 4'd1;
                                    r_state   <= S_IDLE;
                                end else begin
                                    r_pend <= {1'b0, sym} + 5'd1;
                                    r_held <= r_held - {1'b0, r_len};
                                end
                            end else if (r_len == maxlen) begin
                                r_out_vld <= 1'b1;
                                r_fin     <= 1'b1;
                                r_state   <= S_IDLE;
                            end else begin
                                r_len  <= r_len + 5'd1;
                                r_idx  <= r_idx + 8'(cnt);
                                r_code <= (r_code + 21'(cnt)) << 1;
                            end
                        end else if (cat != 4'd0 && r_held < {2'b00, cat}) begin
                            r_state <= S_IDLE;
                        end else begin
                            // residual and reconstruction
                            r_held             <= r_held - {2'b00, cat};
                            r_pend             <= '0;
                            r_pred[r_comp]     <= val;
                            if (r_col == 16'd0) begin
                                r_rfs[r_comp] <= val;
                            end
                            r_out.sample_value <= val;
                            r_out.status       <= ljsd_pkg::ST_SAMPLE;
                            r_out.last_sample  <= last;
                            r_out_vld          <= 1'b1;
                            r_n                <= r_n + 4'd1;
                            if (last) begin
                                r_fin   <= 1'b1;
                                r_state <= S_IDLE;
                            end else if (!r_comp) begin
                                r_comp <= 1'b1;
                            end else begin
                                r_comp <= 1'b0;
                                if (row_end) begin
                                    r_col <= '0;
                                    r_row <= r_row + 16'd1;
                                end else begin
                                    r_col <= r_col + 16'd1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/lossless_jpeg_scan_decoder.sv =====
// ----------------------------------------------------------------------------
// lossless_jpeg_scan_decoder
// Two-component lossless jpeg scan decoder, predictor 1, byte input.
// ----------------------------------------------------------------------------
// Flow: a byte passes the classifier into the command queue; the decoder takes
//   it in S_IDLE, sets up in S_EXEC, then tries code lengths in S_RUN and takes each sample.
// Pacing: a byte completes at most 8 samples before the next is taken; the
//   queue takes new bytes while the decoder works until it is full; a stalled
//   result holds the decoder.
// Reset: synchronous active low; clears queue, position, window and config.
module lossless_jpeg_scan_decoder #(
    parameter int SAMPLE_BITS   = 16,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ljsd_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ljsd_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);

    logic           in_accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    ljsd_pkg::t_cmd f_cmd;
    ljsd_pkg::t_cmd q_cmd;

    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    ljsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_cmd    (f_cmd)
    );

    ljsd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    ljsd_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

// ===== rtl/ljsd_chk.sv =====
// ----------------------------------------------------------------------------
// ljsd_chk
// Port-level checks for the scan decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ljsd_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input ljsd_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input ljsd_pkg::t_out_item o_item,
    input logic                i_cfg_we,
    input logic [2:0]          i_cfg_idx,
    input logic [63:0]         i_cfg_data
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // fault results carry no sample and never end the frame
    a_fault_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != ljsd_pkg::ST_SAMPLE |->
        o_item.sample_value == 16'd0 && !o_item.last_sample)
        else $error("fault result with sample data");

    // after reset the output register is empty and the queue is not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not empty after reset");

    // a final sample is always a good sample of component one
    a_last_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last_sample |->
        o_item.component && o_item.status == ljsd_pkg::ST_SAMPLE)
        else $error("bad final sample");

endmodule

bind lossless_jpeg_scan_decoder ljsd_chk u_ljsd_chk (.*);
